// ===== sv/rcpd_pkg.sv =====
// Shared types, constants and helpers for the run-class pattern detector.
// No dependencies; every other file but rcpd_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none
package rcpd_pkg;

	localparam int SYMS_W    = 16;
	localparam int SYM_SLOTS = SYMS_W / 2;
	localparam int LEN_W     = 4;
	localparam int CFG_IDX_W = 2;

	typedef logic [1:0]        sym_t;
	typedef logic [7:0]        pix_t;
	typedef logic [SYMS_W-1:0] syms_t;
	typedef logic [LEN_W-1:0]  len_t;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd1;

	localparam syms_t SYMS_RESET = 16'd493;
	localparam len_t  LEN_RESET  = 4'd5;

	localparam pix_t PIX_BLACK = 8'd0;
	localparam pix_t PIX_MID   = 8'd128;
	localparam pix_t PIX_WHITE = 8'd255;

	localparam sym_t CLS_OTHER = 2'd0;
	localparam sym_t CLS_BLACK = 2'd1;
	localparam sym_t CLS_MID   = 2'd2;
	localparam sym_t CLS_WHITE = 2'd3;

	function automatic sym_t class_of(input pix_t p);
		sym_t c;
		c = CLS_OTHER;
		if (p == PIX_BLACK)
			c = CLS_BLACK;
		else if (p == PIX_MID)
			c = CLS_MID;
		else if (p == PIX_WHITE)
			c = CLS_WHITE;
		return c;
	endfunction

	// symbols past the register read as zero
	function automatic sym_t symbol_at(input syms_t syms, input logic [4:0] idx);
		sym_t s;
		s = CLS_OTHER;
		if (idx < 5'(SYM_SLOTS))
			s = syms[{idx[2:0], 1'b0} +: 2];
		return s;
	endfunction

endpackage
`default_nettype wire

// ===== sv/rcpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rcpd_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 8
) (
	input  wire                                          clk,
	input  wire                                          we,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                             wdata,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== sv/rcpd_fail_build.sv =====
// Failure-table builder: walks the pattern and writes the prefix table into the RAM.
// Depends on rcpd_pkg; drives the write port and, while busy, the read port of rcpd_ram.
`timescale 1ns / 1ps
`default_nettype none
module rcpd_fail_build #(
	parameter int JW = 4,
	parameter int AW = 3
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire  rcpd_pkg::syms_t syms,
	input  wire  [JW-1:0]         n,
	input  wire  [AW-1:0]         rdata,
	output logic                  busy,
	output logic                  we,
	output logic [AW-1:0]         waddr,
	output logic [AW-1:0]         wdata,
	output logic [AW-1:0]         raddr
);
	import rcpd_pkg::*;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_INIT = 2'd1;
	localparam logic [1:0] B_CMP  = 2'd2;
	localparam logic [1:0] B_WAIT = 2'd3;

	logic [1:0]    state_q;
	logic [JW-1:0] i_q;
	logic [JW-1:0] k_q;
	logic [JW-1:0] k_dec;
	logic [JW-1:0] k_inc;
	logic          sym_eq;

	assign sym_eq = symbol_at(syms, 5'(i_q)) == symbol_at(syms, 5'(k_q));
	assign k_dec  = k_q - JW'(1);
	assign k_inc  = k_q + JW'(1);
	assign busy   = state_q != B_IDLE;

	always_comb begin
		we    = 1'b0;
		waddr = i_q[AW-1:0];
		wdata = '0;
		raddr = k_dec[AW-1:0];
		unique case (state_q)
			B_INIT: begin
				we    = 1'b1;
				waddr = '0;
			end
			B_CMP: begin
				if (i_q < n) begin
					if (sym_eq) begin
						we    = 1'b1;
						wdata = k_inc[AW-1:0];
					end else if (k_q == '0) begin
						we = 1'b1;
					end
				end
			end
			B_IDLE, B_WAIT: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
			i_q     <= '0;
			k_q     <= '0;
		end else if (start) begin
			state_q <= B_INIT;
		end else begin
			unique case (state_q)
				B_IDLE: state_q <= B_IDLE;
				B_INIT: begin
					i_q     <= JW'(1);
					k_q     <= '0;
					state_q <= B_CMP;
				end
				B_CMP: begin
					if (i_q >= n) begin
						state_q <= B_IDLE;
					end else if (sym_eq) begin
						k_q <= k_inc;
						i_q <= i_q + JW'(1);
					end else if (k_q != '0) begin
						// fall back: fetch table[k-1]
						state_q <= B_WAIT;
					end else begin
						i_q <= i_q + JW'(1);
					end
				end
				B_WAIT: begin
					k_q     <= JW'(rdata);
					state_q <= B_CMP;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/rcpd_matcher.sv =====
// Per-pixel run tracking, KMP matcher and output register.
// Depends on rcpd_pkg; reads the failure table through rcpd_ram.
`timescale 1ns / 1ps
`default_nettype none
module rcpd_matcher #(
	parameter int JW = 4,
	parameter int AW = 3
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   accept,
	input  wire  rcpd_pkg::pix_t  pixel,
	input  wire                   line_end,
	input  wire                   cfg_clr,
	input  wire  rcpd_pkg::syms_t syms,
	input  wire  [JW-1:0]         n,
	input  wire  [AW-1:0]         rdata,
	input  wire                   out_stall,
	output logic [AW-1:0]         raddr,
	output logic                  busy,
	output logic                  out_valid,
	output logic                  found
);
	import rcpd_pkg::*;

	localparam logic [1:0] M_IDLE = 2'd0;
	localparam logic [1:0] M_FEED = 2'd1;
	localparam logic [1:0] M_WAIT = 2'd2;
	localparam logic [1:0] M_DONE = 2'd3;

	logic [1:0]    state_q;
	pix_t          prev_q;
	logic          started_q;
	logic          matched_q;
	logic [JW-1:0] ml_q;
	logic [JW-1:0] j_q;
	sym_t          c_q;
	logic          last_q;
	logic          out_valid_q;
	logic          found_q;

	logic          new_run;
	logic          sym_hit;
	logic [JW-1:0] j_dec;
	logic [JW-1:0] j_next;
	logic          slot_free;

	assign new_run   = !started_q || (pixel != prev_q);
	assign sym_hit   = symbol_at(syms, 5'(j_q)) == c_q;
	assign j_dec     = j_q - JW'(1);
	assign j_next    = sym_hit ? j_q + JW'(1) : j_q;
	assign raddr     = j_dec[AW-1:0];
	assign slot_free = !out_valid_q || !out_stall;
	assign busy      = state_q != M_IDLE;
	assign out_valid = out_valid_q;
	assign found     = found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= M_IDLE;
			prev_q      <= PIX_BLACK;
			started_q   <= 1'b0;
			matched_q   <= 1'b0;
			ml_q        <= '0;
			j_q         <= '0;
			c_q         <= CLS_OTHER;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			// in M_DONE the output register is reloaded instead
			if (out_valid_q && !out_stall && state_q != M_DONE)
				out_valid_q <= 1'b0;
			if (cfg_clr)
				ml_q <= '0;
			unique case (state_q)
				M_IDLE: begin
					if (accept) begin
						prev_q    <= pixel;
						started_q <= 1'b1;
						last_q    <= line_end;
						if (new_run && !matched_q) begin
							c_q     <= class_of(pixel);
							j_q     <= (ml_q >= n) ? '0 : ml_q;
							state_q <= M_FEED;
						end else if (line_end) begin
							state_q <= M_DONE;
						end
					end
				end
				M_FEED: begin
					if (j_q != '0 && !sym_hit) begin
						state_q <= M_WAIT;
					end else begin
						if (j_next >= n) begin
							matched_q <= 1'b1;
							ml_q      <= '0;
						end else begin
							ml_q <= j_next;
						end
						state_q <= last_q ? M_DONE : M_IDLE;
					end
				end
				M_WAIT: begin
					j_q     <= JW'(rdata);
					state_q <= M_FEED;
				end
				M_DONE: begin
					// hold until the output register frees up
					if (slot_free) begin
						out_valid_q <= 1'b1;
						found_q     <= matched_q;
						started_q   <= 1'b0;
						matched_q   <= 1'b0;
						ml_q        <= '0;
						state_q     <= M_IDLE;
					end
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/run_class_pattern_detector_top.sv =====
// Top level of the run-class pattern detector: configuration registers and RAM sharing.
// Depends on rcpd_pkg, rcpd_ram, rcpd_fail_build and rcpd_matcher.
`timescale 1ns / 1ps
`default_nettype none
// Pixels of a line enter on pixel/line_end; equal neighbors form one run, each run is
// classed (0 -> 1, 128 -> 2, 255 -> 3, else 0) and the class stream is matched against
// the configured pattern with a KMP automaton whose failure table sits in a small RAM.
// One word leaves on found at each line end. A pixel that starts no new run, or arrives
// after the line has matched, is taken without leaving the idle state. A pixel that starts
// a run before the match passes through the feed state, plus a wait and a feed for each
// fallback step through the failure table (at most pattern length - 1 steps, each a
// registered RAM read). The line-end pixel then passes through a done state, which holds
// while the previous found word is still stalled. After reset and after every write of a
// pattern register the failure table is rebuilt, during which in_stall is high and
// cfg_ready is low. in_stall is also high while a configuration word is offered, so a
// pixel never enters in the same cycle as a register write.
module run_class_pattern_detector_top #(
	parameter int MAX_PATTERN = 8
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  rcpd_pkg::pix_t             pixel,
	input  wire                              line_end,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic                             found,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [rcpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  rcpd_pkg::syms_t            cfg_data
);
	import rcpd_pkg::*;

	localparam int JW = $clog2(MAX_PATTERN + 1);
	localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	syms_t         syms_q;
	len_t          len_q;
	logic [4:0]    len_x;
	logic [4:0]    n_x;
	logic [JW-1:0] n;

	logic          cfg_wr;
	logic          cfg_known;
	logic          accept;

	logic          b_busy;
	logic          b_we;
	logic [AW-1:0] b_waddr;
	logic [AW-1:0] b_wdata;
	logic [AW-1:0] b_raddr;
	logic          m_busy;
	logic [AW-1:0] m_raddr;
	logic [AW-1:0] ram_raddr;
	logic [AW-1:0] ram_rdata;

	// clamp the length to 1..MAX_PATTERN
	assign len_x = {1'b0, len_q};
	assign n_x   = (len_q == '0) ? 5'd1 :
	               ((len_x > 5'(MAX_PATTERN)) ? 5'(MAX_PATTERN) : len_x);
	assign n     = n_x[JW-1:0];

	assign cfg_ready = !b_busy && !m_busy;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cfg_known = cfg_wr && (cfg_index == CFG_SYMBOLS || cfg_index == CFG_LENGTH);
	// hold pixels off while a register write is offered
	assign in_stall  = b_busy || m_busy || cfg_valid;
	assign accept    = in_valid && !in_stall;
	assign ram_raddr = b_busy ? b_raddr : m_raddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			syms_q <= SYMS_RESET;
			len_q  <= LEN_RESET;
		end else if (cfg_wr) begin
			if (cfg_index == CFG_SYMBOLS)
				syms_q <= cfg_data;
			else if (cfg_index == CFG_LENGTH)
				len_q <= cfg_data[LEN_W-1:0];
		end
	end

	rcpd_ram #(
		.WIDTH (AW),
		.DEPTH (MAX_PATTERN)
	) u_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rcpd_fail_build #(
		.JW (JW),
		.AW (AW)
	) u_build (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_known),
		.syms   (syms_q),
		.n      (n),
		.rdata  (ram_rdata),
		.busy   (b_busy),
		.we     (b_we),
		.waddr  (b_waddr),
		.wdata  (b_wdata),
		.raddr  (b_raddr)
	);

	rcpd_matcher #(
		.JW (JW),
		.AW (AW)
	) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.pixel     (pixel),
		.line_end  (line_end),
		.cfg_clr   (cfg_known),
		.syms      (syms_q),
		.n         (n),
		.rdata     (ram_rdata),
		.out_stall (out_stall),
		.raddr     (m_raddr),
		.busy      (m_busy),
		.out_valid (out_valid),
		.found     (found)
	);

	a_rebuild_on_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_known |=> b_busy)
		else $error("pattern write did not start a table rebuild");

	a_no_write_while_matching: assert property (@(posedge clk) disable iff (!arst_n)
		b_we |-> !m_busy)
		else $error("failure table written while a pixel is in flight");

	a_result_from_line: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(m_busy))
		else $error("result word appeared without a line end in progress");

endmodule
`default_nettype wire

// ===== test/run_class_pattern_detector_top_tb.sv =====
// Self-checking bench for run_class_pattern_detector_top: directed and random lines of pixels, checked found flags.
// Depends on rcpd_pkg and the detector RTL; holds its own run-class / KMP predictor.
`timescale 1ns / 1ps
module run_class_pattern_detector_top_tb;
	import rcpd_pkg::*;

	localparam int MAXP       = 8;
	localparam int SEGMENTS   = 12;
	localparam int SEG_WORDS  = 80;
	localparam int SETTLE     = 50;
	localparam int QUIET_MAX  = 3000;

	// indexes past the two registers; writes there are dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef struct packed {
		pix_t pixel;
		logic last;
	} px_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	pix_t                 pixel = '0;
	logic                 line_end = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 found;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	syms_t                cfg_data = '0;

	// predictor state
	syms_t pat_syms;
	len_t  pat_len;
	int    fail_tab [MAXP];
	pix_t  prev_pix = '0;
	bit    line_open = 1'b0;
	int    match_len = 0;
	bit    line_hit = 1'b0;

	px_word_t pend_q [$];
	bit       found_q [$];
	px_word_t held;
	int       words_queued = 0;
	int       words_sent = 0;
	int       lines_seen = 0;
	int       mismatches = 0;
	int       quiet = 0;
	int       send_idle = 10;
	int       recv_stall = 70;

	run_class_pattern_detector_top #(
		.MAX_PATTERN(MAXP)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel     (pixel),
		.line_end  (line_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.found     (found),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int used_len();
		int n;
		n = int'(pat_len);
		if (n < 1)
			n = 1;
		if (n > MAXP)
			n = MAXP;
		return n;
	endfunction

	function automatic sym_t pat_sym(input int idx);
		if (idx >= SYM_SLOTS)
			return CLS_OTHER;
		return pat_syms[2*idx +: 2];
	endfunction

	function automatic sym_t run_class(input pix_t p);
		case (p)
			PIX_BLACK: return CLS_BLACK;
			PIX_MID:   return CLS_MID;
			PIX_WHITE: return CLS_WHITE;
			default:   return CLS_OTHER;
		endcase
	endfunction

	function automatic void rebuild_fail_tab();
		int n, k, i;
		n = used_len();
		k = 0;
		i = 1;
		for (int t = 0; t < MAXP; t++)
			fail_tab[t] = 0;
		while (i < n) begin
			if (pat_sym(i) == pat_sym(k)) begin
				k++;
				fail_tab[i] = k;
				i++;
			end else if (k != 0) begin
				k = fail_tab[k-1];
			end else begin
				fail_tab[i] = 0;
				i++;
			end
		end
	endfunction

	function automatic void advance_match(input sym_t c);
		int n, j;
		n = used_len();
		j = match_len;
		if (j >= n)
			j = 0;
		while (j > 0 && pat_sym(j) != c)
			j = fail_tab[j-1];
		if (pat_sym(j) == c)
			j++;
		if (j >= n) begin
			line_hit = 1'b1;
			j = 0;
		end
		match_len = j;
	endfunction

	function automatic void take_pixel(input pix_t p, input bit last);
		// a new run feeds the matcher until the line has matched
		if ((!line_open || p != prev_pix) && !line_hit)
			advance_match(run_class(p));
		prev_pix  = p;
		line_open = 1'b1;
		if (last) begin
			found_q.push_back(line_hit);
			line_open = 1'b0;
			match_len = 0;
			line_hit  = 1'b0;
		end
	endfunction

	function automatic void add_word(input pix_t p, input bit last);
		pend_q.push_back('{pixel: p, last: last});
		words_queued++;
	endfunction

	function automatic syms_t rand_pattern();
		syms_t s;
		sym_t  a, b;
		if ($urandom_range(1))
			return syms_t'($urandom);
		// two-symbol alphabet: plenty of self-overlap for the fallback path
		a = sym_t'($urandom_range(3));
		b = sym_t'($urandom_range(3));
		for (int k = 0; k < SYM_SLOTS; k++)
			s[2*k +: 2] = $urandom_range(1) ? a : b;
		return s;
	endfunction

	// Build one line from the current pattern: mostly embedded pattern with noise around it.
	function automatic int gen_line(input bit close);
		sym_t cls [$];
		pix_t px [$];
		pix_t v;
		int   n, mode, lim, miss, k;
		n    = used_len();
		mode = $urandom_range(9);
		if (mode <= 5) begin
			lim = $urandom_range(3);
			for (k = 0; k < lim; k++)
				cls.push_back(sym_t'($urandom_range(3)));
			if ($urandom_range(1)) begin
				lim = $urandom_range(n - 1);
				for (k = 0; k < lim; k++)
					cls.push_back(pat_sym(k));
			end
			// near miss: one pattern symbol changed
			miss = (mode == 5) ? int'($urandom_range(n - 1)) : -1;
			for (k = 0; k < n; k++)
				cls.push_back((k == miss) ? sym_t'(pat_sym(k) + 2'd1) : pat_sym(k));
			lim = $urandom_range(3);
			for (k = 0; k < lim; k++)
				cls.push_back(sym_t'($urandom_range(3)));
		end else if (mode <= 8) begin
			lim = $urandom_range(8, 1);
			for (k = 0; k < lim; k++)
				cls.push_back(sym_t'($urandom_range(3)));
		end else begin
			lim = $urandom_range(8, 1);
			for (k = 0; k < lim; k++)
				px.push_back(pix_t'($urandom_range(255)));
		end
		for (k = 0; k < cls.size(); k++) begin
			case (cls[k])
				CLS_BLACK: v = PIX_BLACK;
				CLS_MID:   v = PIX_MID;
				CLS_WHITE: v = PIX_WHITE;
				default: begin
					v = pix_t'($urandom_range(254, 1));
					if (v == PIX_MID)
						v = 8'd129;
				end
			endcase
			repeat ($urandom_range(3, 1))
				px.push_back(v);
		end
		for (k = 0; k < px.size(); k++)
			add_word(px[k], close && (k == px.size() - 1));
		return px.size();
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input syms_t data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		if (idx == CFG_SYMBOLS || idx == CFG_LENGTH) begin
			if (idx == CFG_SYMBOLS)
				pat_syms = data;
			else
				pat_len = data[LEN_W-1:0];
			rebuild_fail_tab();
			match_len = 0;
		end
	endtask

	// hold until every word is in and every flag is out, then let the block settle
	task automatic drain();
		while (words_sent != words_queued || found_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// pixel source
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				take_pixel(held.pixel, held.last);
				words_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					held = pend_q.pop_front();
					in_valid <= 1'b1;
					pixel    <= held.pixel;
					line_end <= held.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result sink and checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (found_q.size() == 0) begin
					flag_mismatch($sformatf("found word %0b with no line pending", found));
				end else begin
					if (found !== found_q[0])
						flag_mismatch($sformatf("line %0d: found %0b, predicted %0b",
							lines_seen, found, found_q[0]));
					void'(found_q.pop_front());
				end
				lines_seen++;
			end
			out_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	// watchdog: nothing moving on any channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				quiet <= 0;
			end else begin
				quiet <= quiet + 1;
				if (quiet >= QUIET_MAX) begin
					$display("watchdog: no word moved for %0d cycles", QUIET_MAX);
					$display("TEST FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		int cnt;
		pat_syms = SYMS_RESET;
		pat_len  = LEN_RESET;
		rebuild_fail_tab();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed lines on the reset pattern 1,3,2,3,1
		add_word(PIX_BLACK, 1'b1);
		add_word(PIX_BLACK, 1'b0); add_word(PIX_WHITE, 1'b0); add_word(PIX_MID, 1'b0);
		add_word(PIX_WHITE, 1'b0); add_word(PIX_BLACK, 1'b1);
		// repeated pixels collapse into runs
		add_word(PIX_BLACK, 1'b0); add_word(PIX_BLACK, 1'b0); add_word(PIX_WHITE, 1'b0);
		add_word(PIX_MID, 1'b0); add_word(PIX_MID, 1'b0); add_word(PIX_WHITE, 1'b0);
		add_word(PIX_BLACK, 1'b1);
		// neighbors of the special values are plain class
		add_word(8'd1, 1'b0); add_word(8'd127, 1'b0); add_word(8'd129, 1'b0);
		add_word(8'd254, 1'b0); add_word(PIX_WHITE, 1'b1);
		// partial match then fallback
		add_word(PIX_BLACK, 1'b0); add_word(PIX_WHITE, 1'b0); add_word(PIX_BLACK, 1'b0);
		add_word(PIX_WHITE, 1'b0); add_word(PIX_MID, 1'b0); add_word(PIX_WHITE, 1'b0);
		add_word(PIX_BLACK, 1'b1);
		drain();

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 4)
				0: begin send_idle = 10; recv_stall = 70; end
				1: begin send_idle = 70; recv_stall = 10; end
				default: begin send_idle = 0; recv_stall = 0; end
			endcase
			case (seg)
				0: begin
					write_reg(CFG_SYMBOLS, SYMS_RESET);
					write_reg(CFG_LENGTH, syms_t'(LEN_RESET));
				end
				1: begin
					write_reg(CFG_SYMBOLS, rand_pattern());
					write_reg(CFG_LENGTH, syms_t'(8));
				end
				2: write_reg(CFG_LENGTH, {syms_t'($urandom)} & 16'hFFF0 | 16'd1);
				3: begin
					// zero length behaves as one
					write_reg(CFG_SYMBOLS, rand_pattern());
					write_reg(CFG_LENGTH, {syms_t'($urandom)} & 16'hFFF0);
				end
				4: begin
					// oversize length clamps to the slot count
					write_reg(CFG_SYMBOLS, 16'hFFFF);
					write_reg(CFG_LENGTH, 16'hFFFF);
				end
				5: begin
					write_reg(CFG_SYMBOLS, 16'h0000);
					write_reg(CFG_LENGTH, syms_t'(3));
				end
				6: begin
					write_reg(CFG_SPARE_A, syms_t'($urandom));
					write_reg(CFG_SPARE_B, syms_t'($urandom));
					write_reg(CFG_SYMBOLS, rand_pattern());
				end
				default: begin
					write_reg(CFG_SYMBOLS, rand_pattern());
					write_reg(CFG_LENGTH, syms_t'($urandom_range(15)));
				end
			endcase
			cnt = 0;
			while (cnt < SEG_WORDS)
				cnt += gen_line(1'b1);
			// leave a line open so the next register write lands mid-line
			if (seg != SEGMENTS - 1 && $urandom_range(2) == 0)
				void'(gen_line(1'b0));
			drain();
		end

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
